// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the bound checker (tle_checker).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/tle_pkg.sv -----
`default_nettype none

package tle_pkg;

   // Line capacity and derived widths.
   localparam int LINE_MAX = 32;
   localparam int LEN_W    = $clog2(LINE_MAX + 1);
   localparam int ADDR_W   = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
   localparam int PC_W     = 5;

   // Character codes.
   localparam logic [7:0] CH_BS  = 8'd8;
   localparam logic [7:0] CH_LF  = 8'd10;
   localparam logic [7:0] CH_CR  = 8'd13;
   localparam logic [7:0] CH_SP  = 8'd32;
   localparam logic [7:0] CH_GT  = 8'd62;
   localparam logic [7:0] CH_DEL = 8'd127;

   // Program addresses that are jump targets.
   localparam logic [PC_W-1:0] PC_IDLE  = 5'd0;
   localparam logic [PC_W-1:0] PC_EOL   = 5'd5;
   localparam logic [PC_W-1:0] PC_LOOP  = 5'd7;
   localparam logic [PC_W-1:0] PC_PRMT  = 5'd10;
   localparam logic [PC_W-1:0] PC_ERASE = 5'd14;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_CONST,
      EMIT_RX,
      EMIT_STORE
   } emit_sel_type;

   typedef enum logic [1:0] {
      LEN_HOLD,
      LEN_APPEND,
      LEN_DEC,
      LEN_CLEAR
   } len_op_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_CRLF,
      COND_ERASE,
      COND_FULL,
      COND_EMPTY,
      COND_IDX_END
   } cond_type;

   typedef struct packed {
      logic              fetch;
      emit_sel_type      emit;
      logic [7:0]        cbyte;
      logic              kind;
      logic              last;
      len_op_type        len_op;
      logic              idx_clr;
      logic              idx_inc;
      cond_type          cond;
      logic [PC_W-1:0]   target;
   } uword_type;

   // Sequencer to datapath: current control word and whether the step retires.
   typedef struct packed {
      uword_type word;
      logic      advance;
   } ctl_type;

   // Datapath to sequencer: branch conditions and output room.
   typedef struct packed {
      logic crlf;
      logic erase;
      logic full;
      logic empty;
      logic idx_end;
      logic out_free;
   } stat_type;

   // Microcode store.
   function automatic uword_type ucode(input logic [PC_W-1:0] pc);
      uword_type w;
      w = '0;
      case (pc)
         5'd0: begin
            w.fetch = 1'b1;
         end
         5'd1: begin
            w.cond   = COND_CRLF;
            w.target = PC_EOL;
         end
         5'd2: begin
            w.cond   = COND_ERASE;
            w.target = PC_ERASE;
         end
         5'd3: begin
            w.cond   = COND_FULL;
            w.target = PC_IDLE;
         end
         5'd4: begin
            w.emit   = EMIT_RX;
            w.last   = 1'b1;
            w.len_op = LEN_APPEND;
            w.cond   = COND_ALWAYS;
            w.target = PC_IDLE;
         end
         5'd5: begin
            w.emit  = EMIT_CONST;
            w.cbyte = CH_CR;
         end
         5'd6: begin
            w.emit    = EMIT_CONST;
            w.cbyte   = CH_LF;
            w.idx_clr = 1'b1;
         end
         5'd7: begin
            w.cond   = COND_IDX_END;
            w.target = PC_PRMT;
         end
         5'd8: begin
            // Read slot: store data for the current index settles here.
            w.cond = COND_NONE;
         end
         5'd9: begin
            w.emit    = EMIT_STORE;
            w.kind    = 1'b1;
            w.idx_inc = 1'b1;
            w.cond    = COND_ALWAYS;
            w.target  = PC_LOOP;
         end
         5'd10: begin
            w.emit   = EMIT_CONST;
            w.cbyte  = CH_GT;
            w.len_op = LEN_CLEAR;
         end
         5'd11: begin
            w.emit  = EMIT_CONST;
            w.cbyte = CH_GT;
         end
         5'd12: begin
            w.emit  = EMIT_CONST;
            w.cbyte = CH_GT;
         end
         5'd13: begin
            w.emit   = EMIT_CONST;
            w.cbyte  = CH_SP;
            w.last   = 1'b1;
            w.cond   = COND_ALWAYS;
            w.target = PC_IDLE;
         end
         5'd14: begin
            w.cond   = COND_EMPTY;
            w.target = PC_IDLE;
         end
         5'd15: begin
            w.emit  = EMIT_CONST;
            w.cbyte = CH_BS;
         end
         5'd16: begin
            w.emit  = EMIT_CONST;
            w.cbyte = CH_SP;
         end
         5'd17: begin
            w.emit   = EMIT_CONST;
            w.cbyte  = CH_BS;
            w.last   = 1'b1;
            w.len_op = LEN_DEC;
            w.cond   = COND_ALWAYS;
            w.target = PC_IDLE;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = PC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tle_sequencer.sv -----
`default_nettype none

module tle_sequencer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tle_pkg::stat_type stat,
   output tle_pkg::ctl_type       ctl
);

   logic [tle_pkg::PC_W-1:0] pc_ff;
   logic [tle_pkg::PC_W-1:0] pc_in;
   tle_pkg::uword_type       word;
   logic                     hold;
   logic                     taken;

   assign word = tle_pkg::ucode(pc_ff);

   // A step stalls while it waits for an input beat or for room at the output.
   always_comb begin
      hold = (word.fetch && !req_valid) ||
             ((word.emit != tle_pkg::EMIT_NONE) && !stat.out_free);
   end

   always_comb begin
      case (word.cond)
         tle_pkg::COND_NONE:    taken = 1'b0;
         tle_pkg::COND_ALWAYS:  taken = 1'b1;
         tle_pkg::COND_CRLF:    taken = stat.crlf;
         tle_pkg::COND_ERASE:   taken = stat.erase;
         tle_pkg::COND_FULL:    taken = stat.full;
         tle_pkg::COND_EMPTY:   taken = stat.empty;
         tle_pkg::COND_IDX_END: taken = stat.idx_end;
         default:               taken = 1'b0;
      endcase
   end

   always_comb begin
      if (hold) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= tle_pkg::PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign req_stall   = !word.fetch;
   assign ctl.word    = word;
   assign ctl.advance = !hold;

endmodule

`default_nettype wire

// ----- rtl/core/tle_datapath.sv -----
`default_nettype none

module tle_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [7:0]       req_rx_byte,
   input  wire tle_pkg::ctl_type ctl,
   output tle_pkg::stat_type     stat,
   input  wire logic             rsp_stall,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_out_kind,
   output logic                  rsp_line_end,
   output logic                  rsp_run_last
);

   logic [7:0]                 line_mem [tle_pkg::LINE_MAX];
   logic [7:0]                 rd_data_ff;
   logic [7:0]                 rx_ff;
   logic [tle_pkg::LEN_W-1:0]  len_ff;
   logic [tle_pkg::LEN_W-1:0]  len_in;
   logic [tle_pkg::LEN_W-1:0]  idx_ff;
   logic [tle_pkg::LEN_W-1:0]  idx_in;
   logic [tle_pkg::LEN_W-1:0]  idx_next;
   logic                       valid_ff;
   logic                       valid_in;
   logic [7:0]                 obyte_ff;
   logic [7:0]                 obyte_in;
   logic                       okind_ff;
   logic                       oend_ff;
   logic                       oend_in;
   logic                       olast_ff;
   logic                       out_free;
   logic                       load;
   logic                       append;

   assign out_free = !valid_ff || !rsp_stall;
   assign load     = ctl.advance && (ctl.word.emit != tle_pkg::EMIT_NONE);
   assign append   = ctl.advance && (ctl.word.len_op == tle_pkg::LEN_APPEND);
   assign idx_next = idx_ff + 1'b1;

   // Line store: one write port for appends, one registered read at the index.
   always_ff @(posedge clock) begin
      if (append) begin
         line_mem[len_ff[tle_pkg::ADDR_W-1:0]] <= rx_ff;
      end
      rd_data_ff <= line_mem[idx_ff[tle_pkg::ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ctl.word.fetch && ctl.advance) begin
         rx_ff <= req_rx_byte;
      end
   end

   always_comb begin
      len_in = len_ff;
      if (ctl.advance) begin
         case (ctl.word.len_op)
            tle_pkg::LEN_HOLD:   len_in = len_ff;
            tle_pkg::LEN_APPEND: len_in = len_ff + 1'b1;
            tle_pkg::LEN_DEC:    len_in = len_ff - 1'b1;
            tle_pkg::LEN_CLEAR:  len_in = '0;
            default:             len_in = len_ff;
         endcase
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (ctl.advance && ctl.word.idx_clr) begin
         idx_in = '0;
      end else if (ctl.advance && ctl.word.idx_inc) begin
         idx_in = idx_next;
      end
   end

   always_comb begin
      case (ctl.word.emit)
         tle_pkg::EMIT_CONST: obyte_in = ctl.word.cbyte;
         tle_pkg::EMIT_RX:    obyte_in = rx_ff;
         tle_pkg::EMIT_STORE: obyte_in = rd_data_ff;
         default:             obyte_in = ctl.word.cbyte;
      endcase
      oend_in = (ctl.word.emit == tle_pkg::EMIT_STORE) && (idx_next == len_ff);
   end

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         len_ff   <= len_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         obyte_ff <= obyte_in;
         okind_ff <= ctl.word.kind;
         oend_ff  <= oend_in;
         olast_ff <= ctl.word.last;
      end
   end

   assign stat.crlf     = (rx_ff == tle_pkg::CH_CR) || (rx_ff == tle_pkg::CH_LF);
   assign stat.erase    = (rx_ff == tle_pkg::CH_BS) || (rx_ff == tle_pkg::CH_DEL);
   assign stat.full     = (len_ff == tle_pkg::LEN_W'(tle_pkg::LINE_MAX));
   assign stat.empty    = (len_ff == '0);
   assign stat.idx_end  = (idx_ff == len_ff);
   assign stat.out_free = out_free;

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = obyte_ff;
   assign rsp_out_kind = okind_ff;
   assign rsp_line_end = oend_ff;
   assign rsp_run_last = olast_ff;

endmodule

`default_nettype wire

// ----- rtl/core/terminal_line_editor.sv -----
// Each input byte runs its own step program, and the next byte is taken only once that
// program is done; result-side stalls hold it up further. For each stored character a
// line end compares the read index, reads the store, then sends an output beat.
// Reset (synchronous, active high) clears the line length, the program counter and the
// output valid; the line store itself is not cleared and holds stale bytes until rewritten.
`default_nettype none

module terminal_line_editor (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_kind,
   output logic            rsp_line_end,
   output logic            rsp_run_last
);

   // The sequencer steps through a fixed program held in the package. Each control word
   // says what byte to send, how the line length and the read index move, and where to
   // jump. A step that emits waits until the output register has room, and the fetch
   // step waits for an input beat, so either side can idle or stall at any time.
   tle_pkg::ctl_type  ctl;
   tle_pkg::stat_type stat;

   tle_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   // The datapath holds the received byte, the line store and its length, the read
   // index for replaying a finished line, and the output register. The output register
   // parts the two sides, so the next input beat is taken while the last result of the
   // previous one still waits to be collected.
   tle_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_rx_byte  (req_rx_byte),
      .ctl          (ctl),
      .stat         (stat),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_kind (rsp_out_kind),
      .rsp_line_end (rsp_line_end),
      .rsp_run_last (rsp_run_last)
   );

endmodule

`default_nettype wire

// ----- rtl/core/tle_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module tle_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic [7:0] req_rx_byte,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_out_kind,
   input wire logic       rsp_line_end,
   input wire logic       rsp_run_last
);

   // A stalled result beat holds its byte, kind and run marker.
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_kind) && $stable(rsp_run_last))

   // A stalled input beat holds its payload.
   `CHK_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_rx_byte))

   // Only command content can close a command line.
   `CHK_IMPLY(a_end_is_cmd, clock, reset, rsp_valid && rsp_line_end, rsp_out_kind)

   // A command byte is never the last beat of an input byte: the prompt follows it.
   `CHK_IMPLY(a_cmd_not_last, clock, reset, rsp_valid && rsp_out_kind, !rsp_run_last)

   // After an input beat the block works on it before taking another.
   `CHK_NEXT(a_one_at_a_time, clock, reset, req_valid && !req_stall, req_stall)

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_rx_byte  (req_rx_byte),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_out_kind (rsp_out_kind),
   .rsp_line_end (rsp_line_end),
   .rsp_run_last (rsp_run_last)
);

`default_nettype wire

// ----- sim/line_echo_checker.sv -----
`timescale 1ns / 100ps

module line_echo_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_out_kind,
   input  logic       rsp_line_end,
   input  logic       rsp_run_last,
   input  logic       end_check,
   output int         error_count,
   output int         beats_waiting,
   output int         beats_checked,
   output int         lines_checked
);

   typedef struct packed {
      logic [7:0] data;
      logic       kind;
      logic       line_end;
      logic       run_last;
   } tx_beat_type;

   // Shadow copy of the line being typed and its length.
   logic [7:0]  line_buf [tle_pkg::LINE_MAX];
   int          line_len;
   tx_beat_type expected_beats [$];
   tx_beat_type got_beat;
   bit          end_checked;

   task automatic flag_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      error_count++;
   endtask

   task automatic queue_beat(input logic [7:0] data, input logic kind, input logic lend);
      tx_beat_type b;
      b.data     = data;
      b.kind     = kind;
      b.line_end = lend;
      b.run_last = 1'b0;
      expected_beats.push_back(b);
   endtask

   // Works out every beat that one received byte causes and queues them in order.
   task automatic model_rx(input logic [7:0] c);
      int          first;
      int          i;
      tx_beat_type tail;
      first = expected_beats.size();
      if (c == tle_pkg::CH_CR || c == tle_pkg::CH_LF) begin
         queue_beat(tle_pkg::CH_CR, 1'b0, 1'b0);
         queue_beat(tle_pkg::CH_LF, 1'b0, 1'b0);
         for (i = 0; i < line_len; i++) begin
            queue_beat(line_buf[i], 1'b1, (i + 1 == line_len));
         end
         line_len = 0;
         queue_beat(tle_pkg::CH_GT, 1'b0, 1'b0);
         queue_beat(tle_pkg::CH_GT, 1'b0, 1'b0);
         queue_beat(tle_pkg::CH_GT, 1'b0, 1'b0);
         queue_beat(tle_pkg::CH_SP, 1'b0, 1'b0);
      end else if (c == tle_pkg::CH_BS || c == tle_pkg::CH_DEL) begin
         if (line_len > 0) begin
            queue_beat(tle_pkg::CH_BS, 1'b0, 1'b0);
            queue_beat(tle_pkg::CH_SP, 1'b0, 1'b0);
            queue_beat(tle_pkg::CH_BS, 1'b0, 1'b0);
            line_len--;
         end
      end else if (line_len < tle_pkg::LINE_MAX) begin
         queue_beat(c, 1'b0, 1'b0);
         line_buf[line_len] = c;
         line_len++;
      end
      // The final beat of the run carries the run marker.
      if (expected_beats.size() > first) begin
         tail = expected_beats.pop_back();
         tail.run_last = 1'b1;
         expected_beats.push_back(tail);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         line_len = 0;
         expected_beats.delete();
         end_checked = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            model_rx(req_rx_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               flag_mismatch($sformatf("unexpected beat, byte %0d", rsp_out_byte));
            end else begin
               got_beat = expected_beats.pop_front();
               if (rsp_out_byte !== got_beat.data)
                  flag_mismatch($sformatf("out_byte %0d, expected %0d",
                                          rsp_out_byte, got_beat.data));
               if (rsp_out_kind !== got_beat.kind)
                  flag_mismatch($sformatf("out_kind %0b, expected %0b",
                                          rsp_out_kind, got_beat.kind));
               if (rsp_line_end !== got_beat.line_end)
                  flag_mismatch($sformatf("line_end %0b, expected %0b",
                                          rsp_line_end, got_beat.line_end));
               if (rsp_run_last !== got_beat.run_last)
                  flag_mismatch($sformatf("run_last %0b, expected %0b",
                                          rsp_run_last, got_beat.run_last));
               beats_checked++;
               if (got_beat.line_end) lines_checked++;
            end
         end
         if (end_check && !end_checked) begin
            end_checked = 1'b1;
            if (expected_beats.size() != 0)
               flag_mismatch($sformatf("%0d beats never arrived", expected_beats.size()));
         end
      end
      beats_waiting <= expected_beats.size();
   end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

   // The run is ended by force if it gets this far.
   localparam int CLOCK_LIMIT   = 1_000_000;
   localparam int RESET_CYCLES  = 12;
   // Items per idling phase; with the directed parts this gives roughly 380 items.
   localparam int PHASE_ITEMS   = 75;
   // The receiver holds off this long once, far longer than any single run of beats.
   localparam int LONG_HOLD     = 300;
   // A dropped byte or an erase on an empty line gives no beat, so the block may
   // still be busy after the last expected beat; this settling time covers that.
   localparam int SETTLE_CYCLES = 20;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_kind;
   logic       rsp_line_end;
   logic       rsp_run_last;
   logic       end_check = 1'b0;

   int error_count;
   int beats_waiting;
   int beats_checked;
   int lines_checked;

   // Idling percentages for the current phase, and the request for the long hold-off.
   int send_idle_pct  = 0;
   int stall_idle_pct = 0;
   bit hold_armed     = 1'b0;
   int items_sent     = 0;
   int cycle_count    = 0;

   always #10 clock = ~clock;

   terminal_line_editor i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_kind (rsp_out_kind),
      .rsp_line_end (rsp_line_end),
      .rsp_run_last (rsp_run_last)
   );

   line_echo_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_kind  (rsp_out_kind),
      .rsp_line_end  (rsp_line_end),
      .rsp_run_last  (rsp_run_last),
      .end_check     (end_check),
      .error_count   (error_count),
      .beats_waiting (beats_waiting),
      .beats_checked (beats_checked),
      .lines_checked (lines_checked)
   );

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CLOCK_LIMIT) begin
         $display("Timeout after %0d cycles with %0d beats outstanding.",
                  cycle_count, beats_waiting);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Result side. Each cycle it stalls at the phase's rate, except while a long
   // hold-off is running; the hold-off is counted here so that the sender can keep
   // offering bytes meanwhile and the block backs up into its input.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_armed && hold_left == 0) begin
            hold_left  = LONG_HOLD;
            hold_armed = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_idle_pct);
         end
      end
   end

   // Offers one byte, after a random number of idle cycles, and returns at the
   // edge where the beat is taken. The byte stays put while the block stalls.
   task automatic push_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Stops sending and waits until the checker holds no more expected beats.
   // At least one edge always passes, so valid is never lowered and raised in
   // the same step.
   task automatic wait_line_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (beats_waiting != 0) @(posedge clock);
   endtask

   // Types one line: mostly ordinary bytes with random content, some erases,
   // a little noise of any value, then CR or LF. A long line is typed near the
   // capacity and can run past it, dropping its trailing bytes.
   task automatic type_line(input bit long_line);
      int          n;
      int          k;
      int          pick;
      logic [7:0]  c;
      n = long_line ? $urandom_range(tle_pkg::LINE_MAX - 2, tle_pkg::LINE_MAX + 4)
                    : $urandom_range(0, 8);
      for (k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            c = pick[0] ? tle_pkg::CH_BS : tle_pkg::CH_DEL;
         end else if (pick < 14) begin
            c = 8'($urandom_range(255));
         end else begin
            c = 8'($urandom_range(255));
            while (c == tle_pkg::CH_CR || c == tle_pkg::CH_LF ||
                   c == tle_pkg::CH_BS || c == tle_pkg::CH_DEL)
               c = 8'($urandom_range(255));
         end
         push_byte(c);
      end
      push_byte($urandom_range(1) ? tle_pkg::CH_CR : tle_pkg::CH_LF);
   endtask

   // Directed opening: line ends and erases on an empty line, the byte extremes
   // (zero included, which is stored like any other byte), bytes next to the
   // control codes, both erase codes on a filled line, and both line ends.
   logic [7:0] directed_bytes [] = '{
      tle_pkg::CH_CR, tle_pkg::CH_LF, tle_pkg::CH_BS, tle_pkg::CH_DEL,
      8'h00, 8'hFF, 8'h41, 8'h80, tle_pkg::CH_BS, tle_pkg::CH_DEL,
      8'h7E, 8'h01, 8'h55, 8'hAA, tle_pkg::CH_CR,
      8'h07, 8'h09, 8'h0B, 8'h0C, 8'h0E, 8'h1F, tle_pkg::CH_LF
   };

   initial begin : stimulus
      int phase;
      int k;
      int goal;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_bytes[k]) push_byte(directed_bytes[k]);
      wait_line_drained();

      // Long hold-off: the receiver freezes while a full-speed line keeps
      // coming, so the block fills up and has to stall its input.
      hold_armed = 1'b1;
      for (k = 0; k < 10; k++) push_byte(8'($urandom_range(32, 126)));
      push_byte(tle_pkg::CH_CR);
      wait_line_drained();

      // Fill the line completely so that later bytes are dropped, then show that
      // an erase frees one slot again.
      for (k = 0; k < tle_pkg::LINE_MAX + 3; k++)
         push_byte(8'(8'h20 + $urandom_range(0, 94)));
      push_byte(tle_pkg::CH_BS);
      push_byte(8'($urandom_range(255) & 8'hF0 | 8'h03));
      push_byte(tle_pkg::CH_LF);
      wait_line_drained();

      // Four idling mixes: none, sender idle, receiver stalling, both.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_idle_pct = 0;  end
            1: begin send_idle_pct = 63; stall_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_idle_pct = 63; end
            default: begin send_idle_pct = 27; stall_idle_pct = 27; end
         endcase
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) type_line($urandom_range(9) == 0);
         wait_line_drained();
      end

      send_idle_pct  = 0;
      stall_idle_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      end_check <= 1'b1;
      repeat (2) @(posedge clock);

      $display("Sent %0d bytes: line ends, erases, full lines and four idle/stall mixes.",
               items_sent);
      $display("Checked %0d result beats, %0d of them closing a command line.",
               beats_checked, lines_checked);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- terminal_line_editor.f -----
+incdir+rtl/core
rtl/core/tle_pkg.sv
rtl/core/tle_sequencer.sv
rtl/core/tle_datapath.sv
rtl/core/terminal_line_editor.sv
rtl/core/tle_checker.sv
sim/line_echo_checker.sv
sim/testbench.sv
